// ===== rtl/shfh_pkg.sv =====
`default_nettype none
// ============================================================================
// shfh_pkg: shared types for the streaming string hash
// Round kinds and the entry format that passes from the front end to the
// hashing back end through the command queue.
// ============================================================================
package shfh_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QCNT_W      = 3;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_ONE,
        KIND_TWO,
        KIND_THREE,
        KIND_FULL
    } round_kind_t;

    typedef struct packed {
        logic [31:0] data_word;
        round_kind_t kind;
        logic        load_seed;
        logic [31:0] seed;
        logic        last;
    } hash_cmd_t;

endpackage : shfh_pkg
`default_nettype wire

// ===== rtl/superfast_string_hash.sv =====
`default_nettype none
// ============================================================================
// superfast_string_hash: streaming 32-bit string hash
// Hashes a message delivered as little-endian 32-bit words.
// ============================================================================
// Input channel (in_valid/in_ready): one word per transaction with its byte
// count, first/last marks and, on the first word, the total byte length
// that seeds the hash. Words that arrive outside a message are dropped.
// Output channel (out_valid/out_ready): one transaction per message, taken
// on the word marked last, carrying the finished hash.
// Throughput is one word per cycle while the command queue has room. The
// back end runs one round per cycle and stalls only a last word whose
// result slot is full, so words of one message flow back to back unless
// held results fill the queue. The last word passes the command queue,
// then the round register and the avalanche/output register to out_valid.
// When the receiver stalls, one result waits in the output register, one
// in the round register, and the four-entry queue absorbs further words
// before in_ready drops; non-final words keep flowing past a held result.
// Reset clears the open-message flag, the running hash, the queue and all
// valid flags; no clearing pass is needed.
// ============================================================================
module superfast_string_hash #(
    parameter logic [31:0] MAX_LENGTH = 32'd65535
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [31:0]  data_word,
    input  wire logic [2:0]   byte_count,
    input  wire logic         first,
    input  wire logic         last,
    input  wire logic [15:0]  total_length,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [31:0]       hash_value
);

    logic                 push_valid;
    logic                 push_ready;
    shfh_pkg::hash_cmd_t  push_cmd;
    logic                 pop_valid;
    logic                 pop_ready;
    shfh_pkg::hash_cmd_t  pop_cmd;
    logic                 res_valid;
    logic                 res_ready;
    logic [31:0]          res_hash;

    shfh_front #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_word    (data_word),
        .byte_count   (byte_count),
        .first        (first),
        .last         (last),
        .total_length (total_length),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_cmd     (push_cmd)
    );

    shfh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    shfh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_hash  (res_hash)
    );

    shfh_finish u_finish (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_hash   (res_hash),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash_value (hash_value)
    );

endmodule : superfast_string_hash
`default_nettype wire

// ===== rtl/shfh_front.sv =====
`default_nettype none
// ============================================================================
// shfh_front: input front end
// Tracks whether a message is open, drops words outside a message, clamps
// the byte count, saturates the seed and turns each word into a command.
// ============================================================================
module shfh_front #(
    parameter logic [31:0] MAX_LENGTH = 32'd65535
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [31:0]       data_word,
    input  wire logic [2:0]        byte_count,
    input  wire logic              first,
    input  wire logic              last,
    input  wire logic [15:0]       total_length,
    output logic                   push_valid,
    input  wire logic              push_ready,
    output shfh_pkg::hash_cmd_t    push_cmd
);

    logic        in_message_reg;
    logic        in_message_next;
    logic        accept;
    logic        keep;
    logic [31:0] len_ext;

    assign in_ready   = push_ready;
    assign accept     = in_valid && push_ready;
    assign keep       = first || in_message_reg;
    assign push_valid = accept && keep;
    assign len_ext    = {16'b0, total_length};

    always_comb
    begin
        push_cmd.data_word = data_word;
        push_cmd.load_seed = first;
        push_cmd.seed      = (len_ext > MAX_LENGTH) ? MAX_LENGTH : len_ext;
        push_cmd.last      = last;
        case (byte_count)
            3'd0:    push_cmd.kind = shfh_pkg::KIND_NONE;
            3'd1:    push_cmd.kind = shfh_pkg::KIND_ONE;
            3'd2:    push_cmd.kind = shfh_pkg::KIND_TWO;
            3'd3:    push_cmd.kind = shfh_pkg::KIND_THREE;
            default: push_cmd.kind = shfh_pkg::KIND_FULL;
        endcase
    end

    always_comb
    begin
        in_message_next = in_message_reg;
        if (accept && keep)
        begin
            in_message_next = !last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_message_reg <= 1'b0;
        end
        else
        begin
            in_message_reg <= in_message_next;
        end
    end

endmodule : shfh_front
`default_nettype wire

// ===== rtl/shfh_queue.sv =====
`default_nettype none
// ============================================================================
// shfh_queue: command queue
// A small FIFO that lets the front end and the hashing back end stall
// independently of each other.
// ============================================================================
module shfh_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push_valid,
    output logic                      push_ready,
    input  wire shfh_pkg::hash_cmd_t  push_cmd,
    output logic                      pop_valid,
    input  wire logic                 pop_ready,
    output shfh_pkg::hash_cmd_t       pop_cmd
);

    shfh_pkg::hash_cmd_t                 entry_reg [shfh_pkg::QUEUE_DEPTH];
    logic [shfh_pkg::QPTR_W-1:0]         wr_ptr_reg;
    logic [shfh_pkg::QPTR_W-1:0]         wr_ptr_next;
    logic [shfh_pkg::QPTR_W-1:0]         rd_ptr_reg;
    logic [shfh_pkg::QPTR_W-1:0]         rd_ptr_next;
    logic [shfh_pkg::QCNT_W-1:0]         count_reg;
    logic [shfh_pkg::QCNT_W-1:0]         count_next;
    logic                                do_push;
    logic                                do_pop;

    assign push_ready = (count_reg != shfh_pkg::QCNT_W'(shfh_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + shfh_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + shfh_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + shfh_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - shfh_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule : shfh_queue
`default_nettype wire

// ===== rtl/shfh_back.sv =====
`default_nettype none
// ============================================================================
// shfh_back: hashing back end
// Holds the running hash, applies the full-word or tail round of each
// command and hands the pre-avalanche hash of a finished message onward.
// ============================================================================
module shfh_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 pop_valid,
    output logic                      pop_ready,
    input  wire shfh_pkg::hash_cmd_t  pop_cmd,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output logic [31:0]               res_hash
);

    logic [31:0] running_hash_reg;
    logic [31:0] running_hash_next;
    logic [31:0] res_hash_reg;
    logic [31:0] res_hash_next;
    logic        res_valid_reg;
    logic        res_valid_next;
    logic        slot_free;
    logic        do_pop;
    logic [31:0] h_base;
    logic [31:0] h_round;
    logic [31:0] w;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;

    assign slot_free = !res_valid_reg || res_ready;
    assign pop_ready = !pop_cmd.last || slot_free;
    assign do_pop    = pop_valid && pop_ready;
    assign res_valid = res_valid_reg;
    assign res_hash  = res_hash_reg;
    assign w         = pop_cmd.data_word;
    assign h_base    = pop_cmd.load_seed ? pop_cmd.seed : running_hash_reg;

    always_comb
    begin
        a = '0;
        b = '0;
        c = '0;
        case (pop_cmd.kind)
            shfh_pkg::KIND_FULL:
            begin
                a = h_base + {16'b0, w[15:0]};
                b = (a << 16) ^ ({16'b0, w[31:16]} << 11) ^ a;
                h_round = b + (b >> 11);
            end
            shfh_pkg::KIND_THREE:
            begin
                a = h_base + {16'b0, w[15:0]};
                b = a ^ (a << 16);
                c = b ^ ({{24{w[23]}}, w[23:16]} << 18);
                h_round = c + (c >> 11);
            end
            shfh_pkg::KIND_TWO:
            begin
                a = h_base + {16'b0, w[15:0]};
                b = a ^ (a << 11);
                h_round = b + (b >> 17);
            end
            shfh_pkg::KIND_ONE:
            begin
                // The single byte is taken as a signed char.
                a = h_base + {{24{w[7]}}, w[7:0]};
                b = a ^ (a << 10);
                h_round = b + (b >> 1);
            end
            default:
            begin
                h_round = h_base;
            end
        endcase
    end

    always_comb
    begin
        running_hash_next = running_hash_reg;
        res_hash_next     = res_hash_reg;
        res_valid_next    = res_valid_reg && !res_ready;
        if (do_pop)
        begin
            if (pop_cmd.last)
            begin
                running_hash_next = '0;
                res_hash_next     = h_round;
                res_valid_next    = 1'b1;
            end
            else
            begin
                running_hash_next = h_round;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_hash_reg <= '0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            running_hash_reg <= running_hash_next;
            res_valid_reg    <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_hash_reg <= res_hash_next;
    end

endmodule : shfh_back
`default_nettype wire

// ===== rtl/shfh_finish.sv =====
`default_nettype none
// ============================================================================
// shfh_finish: avalanche and output register
// Applies the six-step final mix to a finished hash and holds the result
// on the output channel until the receiver takes it.
// ============================================================================
module shfh_finish (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         res_valid,
    output logic              res_ready,
    input  wire logic [31:0]  res_hash,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [31:0]       hash_value
);

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] hash_value_reg;
    logic [31:0] hash_value_next;
    logic [31:0] s1;
    logic [31:0] s2;
    logic [31:0] s3;
    logic [31:0] s4;
    logic [31:0] s5;
    logic [31:0] s6;

    assign res_ready  = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign hash_value = hash_value_reg;

    always_comb
    begin
        s1 = res_hash ^ (res_hash << 3);
        s2 = s1 + (s1 >> 5);
        s3 = s2 ^ (s2 << 4);
        s4 = s3 + (s3 >> 17);
        s5 = s4 ^ (s4 << 25);
        s6 = s5 + (s5 >> 6);
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ready;
        hash_value_next = hash_value_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next  = 1'b1;
            hash_value_next = s6;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_value_reg <= hash_value_next;
    end

endmodule : shfh_finish
`default_nettype wire

// ===== tb/tb_superfast_string_hash.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_superfast_string_hash: self-checking bench for the streaming string hash
// Feeds directed corner words and then random, mostly well-formed messages
// through the valid/ready input, predicts each finished hash in a tracker
// class, and compares every output transaction in order. Both sides idle at
// random; the receiver also holds off for a long stretch to back up the block.
// ============================================================================
module tb_superfast_string_hash;

    localparam logic [31:0] SEED_LIMIT   = 32'd65535;
    localparam int unsigned WORD_TARGET  = 1075;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned REPORT_LIMIT = 10;

    // Tracks the open message and the running hash, and holds the finished
    // hashes that the block still owes.
    class hash_tracker;
        logic [31:0] running;
        bit          open_msg;
        logic [31:0] expected_hashes[$];
        int unsigned failures;

        function new();
            running  = '0;
            open_msg = 1'b0;
            failures = 0;
        endfunction

        function int unsigned pending();
            return expected_hashes.size();
        endfunction

        // Returns 1 when the word takes part in a message, 0 when ignored.
        function bit note_word(logic [31:0] w, logic [2:0] cnt, bit is_first,
                               bit is_last, logic [15:0] len);
            logic [31:0] h;
            logic [31:0] t;
            shfh_pkg::round_kind_t kind;
            if (is_first)
            begin
                h = {16'd0, len};
                if (h > SEED_LIMIT)
                    h = SEED_LIMIT;
                open_msg = 1'b1;
            end
            else if (!open_msg)
                return 1'b0;
            else
                h = running;

            kind = (cnt >= 3'd4) ? shfh_pkg::KIND_FULL : shfh_pkg::round_kind_t'(cnt);
            case (kind)
                shfh_pkg::KIND_FULL:
                begin
                    h = h + {16'd0, w[15:0]};
                    t = ({16'd0, w[31:16]} << 11) ^ h;
                    h = (h << 16) ^ t;
                    h = h + (h >> 11);
                end
                shfh_pkg::KIND_THREE:
                begin
                    h = h + {16'd0, w[15:0]};
                    h = h ^ (h << 16);
                    h = h ^ ({{24{w[23]}}, w[23:16]} << 18);
                    h = h + (h >> 11);
                end
                shfh_pkg::KIND_TWO:
                begin
                    h = h + {16'd0, w[15:0]};
                    h = h ^ (h << 11);
                    h = h + (h >> 17);
                end
                shfh_pkg::KIND_ONE:
                begin
                    h = h + {{24{w[7]}}, w[7:0]};
                    h = h ^ (h << 10);
                    h = h + (h >> 1);
                end
                default: ;
            endcase

            if (is_last)
            begin
                h = h ^ (h << 3);
                h = h + (h >> 5);
                h = h ^ (h << 4);
                h = h + (h >> 17);
                h = h ^ (h << 25);
                h = h + (h >> 6);
                expected_hashes.push_back(h);
                running  = '0;
                open_msg = 1'b0;
            end
            else
                running = h;
            return 1'b1;
        endfunction

        function void check_hash(logic [31:0] actual);
            logic [31:0] want;
            if (expected_hashes.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("ERROR: unexpected hash %08h at %0t", actual, $realtime);
                return;
            end
            want = expected_hashes.pop_front();
            if (actual !== want)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("ERROR: hash_value expected %08h actual %08h at %0t",
                             want, actual, $realtime);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        first;
    logic        last;
    logic [15:0] total_length;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] hash_value;

    hash_tracker tracker = new();
    int unsigned words_taken;
    int unsigned cycle_count;
    bit          sender_calm;
    bit          receiver_calm;
    bit          receiver_hold;

    superfast_string_hash dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_word    (data_word),
        .byte_count   (byte_count),
        .first        (first),
        .last         (last),
        .total_length (total_length),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hash_value   (hash_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_hash(hash_value);
    end

    // Receiver: random back-pressure, plus one long hold on request.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (receiver_hold)
            begin
                receiver_hold = 1'b0;
                out_ready     = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready = receiver_calm || ($urandom_range(0, 99) >= 10);
        end
    end

    // Offers one word and returns at the falling edge after its transaction.
    task automatic send_word(input logic [31:0] w, input logic [2:0] cnt,
                             input bit is_first, input bit is_last,
                             input logic [15:0] len);
        while (!sender_calm && $urandom_range(0, 99) < 10)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid     = 1'b1;
        data_word    = w;
        byte_count   = cnt;
        first        = is_first;
        last         = is_last;
        total_length = len;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (tracker.note_word(w, cnt, is_first, is_last, len))
            words_taken++;
        @(negedge clk);
    endtask

    // Well-formed message of nbytes random bytes with the given length field.
    task automatic send_message(input int unsigned nbytes, input logic [15:0] len);
        int unsigned nwords;
        int unsigned i;
        logic [2:0]  cnt;
        nwords = (nbytes == 0) ? 1 : (nbytes + 3) / 4;
        for (i = 0; i < nwords; i++)
        begin
            cnt = (i + 1 < nwords) ? 3'd4 : 3'(nbytes - 4 * (nwords - 1));
            send_word($urandom, cnt, i == 0, i + 1 == nwords, len);
        end
    endtask

    task automatic wait_for_drain();
        in_valid = 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int unsigned pick;
        int unsigned nbytes;
        int unsigned n;
        int unsigned i;
        logic [15:0] len;
        bit          hold_done;
        bit          drain_done;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        data_word     = '0;
        byte_count    = '0;
        first         = 1'b0;
        last          = 1'b0;
        total_length  = '0;
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;
        receiver_hold = 1'b0;
        words_taken   = 0;
        cycle_count   = 0;
        hold_done     = 1'b0;
        drain_done    = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // A word with no open message must be dropped.
        send_word(32'hDEADBEEF, 3'd4, 1'b0, 1'b1, 16'd4);
        // Empty message.
        send_word(32'h0, 3'd0, 1'b1, 1'b1, 16'd0);
        // One-byte tails, negative with junk above the byte and positive, then a two-byte tail.
        send_word(32'hFFFFFF80, 3'd1, 1'b1, 1'b1, 16'd1);
        send_word(32'h0000007F, 3'd1, 1'b1, 1'b1, 16'd1);
        send_word(32'hA5A5FFFF, 3'd2, 1'b1, 1'b1, 16'd2);
        // Three-byte tails with the sign bit of the third byte set and clear.
        send_word(32'h0080FFFF, 3'd3, 1'b1, 1'b1, 16'd3);
        send_word(32'hFF7F0000, 3'd3, 1'b1, 1'b1, 16'd3);
        send_word(32'hFFFFFFFF, 3'd4, 1'b1, 1'b1, 16'd4);
        send_word(32'h00000000, 3'd4, 1'b1, 1'b1, 16'hFFFF);
        // Byte counts above four behave as full words.
        send_word(32'h12345678, 3'd5, 1'b1, 1'b1, 16'd4);
        send_word(32'h9ABCDEF0, 3'd6, 1'b1, 1'b1, 16'd4);
        send_word(32'h0F1E2D3C, 3'd7, 1'b1, 1'b1, 16'd4);
        // A new first word abandons the open message.
        send_word(32'h11111111, 3'd4, 1'b1, 1'b0, 16'd8);
        send_word(32'h22222222, 3'd4, 1'b1, 1'b1, 16'd4);
        // A short first word keeps the message open.
        send_word(32'h80FF7F01, 3'd2, 1'b1, 1'b0, 16'h8000);
        send_word(32'hC3C3C3C3, 3'd4, 1'b0, 1'b0, 16'h7FFF);
        send_word(32'h00FF8000, 3'd3, 1'b0, 1'b1, 16'h0000);
        // Last word with no bytes just closes the message.
        send_word(32'h01020304, 3'd4, 1'b1, 1'b0, 16'd8);
        send_word(32'h05060708, 3'd4, 1'b0, 1'b0, 16'd8);
        send_word(32'hFFFFFFFF, 3'd0, 1'b0, 1'b1, 16'd8);
        // Length field unrelated to the bytes sent.
        send_word(32'h00000081, 3'd1, 1'b1, 1'b1, 16'hFFFF);

        while (words_taken < WORD_TARGET)
        begin
            if (!hold_done && words_taken >= 300)
            begin
                hold_done     = 1'b1;
                receiver_hold = 1'b1;
            end
            sender_calm   = (words_taken >= 450 && words_taken < 650);
            receiver_calm = sender_calm;
            if (!drain_done && words_taken >= 750)
            begin
                drain_done = 1'b1;
                wait_for_drain();
            end

            pick = $urandom_range(0, 99);
            if (pick < 78)
            begin
                nbytes = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 64)
                                                      : $urandom_range(0, 24);
                len = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(nbytes);
                send_message(nbytes, len);
            end
            else if (pick < 86)
            begin
                // Message with odd byte counts along the way.
                n = $urandom_range(1, 4);
                send_word($urandom, 3'($urandom_range(0, 7)), 1'b1, 1'b0,
                          16'($urandom));
                for (i = 0; i < n; i++)
                    send_word($urandom, 3'($urandom_range(0, 7)), 1'b0, 1'b0,
                              16'($urandom));
                send_word($urandom, 3'($urandom_range(0, 4)), 1'b0, 1'b1,
                          16'($urandom));
            end
            else if (pick < 93)
            begin
                // Message cut off before its last word.
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++)
                    send_word($urandom, 3'd4, i == 0, 1'b0, 16'($urandom));
            end
            else
                send_word($urandom, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 16'($urandom));
        end

        sender_calm   = 1'b0;
        receiver_calm = 1'b0;
        wait_for_drain();
        repeat (10) @(negedge clk);
        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
